### rtl/prs80_pkg.sv
`default_nettype none

package prs80_pkg;

  localparam int unsigned ROUNDS     = 31;
  localparam int unsigned ROUND_KEYS = 32;
  localparam int unsigned RK_IDX_W   = 5;
  localparam int unsigned CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 4'd1;

  localparam logic OP_ENCRYPT = 1'b0;

  typedef struct packed {
    logic        vld;
    logic        op;
    logic        last;
    logic [63:0] state;
  } item_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] v);
    logic [3:0] r;
    case (v)
      4'h0: r = 4'hC;
      4'h1: r = 4'h5;
      4'h2: r = 4'h6;
      4'h3: r = 4'hB;
      4'h4: r = 4'h9;
      4'h5: r = 4'h0;
      4'h6: r = 4'hA;
      4'h7: r = 4'hD;
      4'h8: r = 4'h3;
      4'h9: r = 4'hE;
      4'hA: r = 4'hF;
      4'hB: r = 4'h8;
      4'hC: r = 4'h4;
      4'hD: r = 4'h7;
      4'hE: r = 4'h1;
      default: r = 4'h2;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] v);
    logic [3:0] r;
    case (v)
      4'h0: r = 4'h5;
      4'h1: r = 4'hE;
      4'h2: r = 4'hF;
      4'h3: r = 4'h8;
      4'h4: r = 4'hC;
      4'h5: r = 4'h1;
      4'h6: r = 4'h2;
      4'h7: r = 4'hD;
      4'h8: r = 4'hB;
      4'h9: r = 4'h4;
      4'hA: r = 4'h6;
      4'hB: r = 4'h3;
      4'hC: r = 4'h0;
      4'hD: r = 4'h7;
      4'hE: r = 4'h9;
      default: r = 4'hA;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] sbox_layer_fwd(input logic [63:0] s);
    logic [63:0] o;
    for (int n = 0; n < 16; n++) begin
      o[4*n +: 4] = sbox_fwd(s[4*n +: 4]);
    end
    return o;
  endfunction

  function automatic logic [63:0] sbox_layer_inv(input logic [63:0] s);
    logic [63:0] o;
    for (int n = 0; n < 16; n++) begin
      o[4*n +: 4] = sbox_inv(s[4*n +: 4]);
    end
    return o;
  endfunction

  // bit k moves to 16k mod 63, bit 63 stays
  function automatic logic [63:0] perm_fwd(input logic [63:0] s);
    logic [63:0] o;
    for (int k = 0; k < 63; k++) begin
      o[(16 * k) % 63] = s[k];
    end
    o[63] = s[63];
    return o;
  endfunction

  // bit k moves to 4k mod 63, bit 63 stays
  function automatic logic [63:0] perm_inv(input logic [63:0] s);
    logic [63:0] o;
    for (int k = 0; k < 63; k++) begin
      o[(4 * k) % 63] = s[k];
    end
    o[63] = s[63];
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/prs80_key_expand.sv
`default_nettype none

module prs80_key_expand (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [prs80_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                     cfg_data,
  output logic                                 busy,
  output logic [63:0]                          rk [prs80_pkg::ROUND_KEYS]
);

  logic [63:0] key_high;
  logic [15:0] key_low;
  logic [63:0] hi;
  logic [15:0] lo;
  logic [prs80_pkg::RK_IDX_W-1:0] cnt;

  logic [79:0] sched_rot;
  logic [79:0] sched_next;
  logic [prs80_pkg::RK_IDX_W-1:0] rc;

  always_comb begin
    rc = cnt + 5'd1;
    sched_rot = {hi[2:0], lo, hi[63:3]};
    sched_next = sched_rot;
    sched_next[79:76] = prs80_pkg::sbox_fwd(sched_rot[79:76]);
    sched_next[19:15] = sched_rot[19:15] ^ rc;
  end

  // restart the expansion after reset and after every key write
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      hi       <= '0;
      lo       <= '0;
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (cfg_valid && cfg_index == prs80_pkg::CFG_KEY_HIGH) begin
      key_high <= cfg_data;
      hi       <= cfg_data;
      lo       <= key_low;
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (cfg_valid && cfg_index == prs80_pkg::CFG_KEY_LOW) begin
      key_low  <= cfg_data[15:0];
      hi       <= key_high;
      lo       <= cfg_data[15:0];
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      hi  <= sched_next[79:16];
      lo  <= sched_next[15:0];
      cnt <= cnt + 5'd1;
      if (cnt == 5'(prs80_pkg::ROUND_KEYS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rk[cnt] <= hi;
    end
  end

endmodule

`default_nettype wire

### rtl/prs80_round.sv
`default_nettype none

module prs80_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire prs80_pkg::item_t item_in,
  input  wire logic [63:0]     rk_enc,
  input  wire logic [63:0]     rk_dec,
  input  wire logic [63:0]     post_enc,
  input  wire logic [63:0]     post_dec,
  output prs80_pkg::item_t     item_out
);

  logic [63:0] state_next;

  always_comb begin
    if (item_in.op == prs80_pkg::OP_ENCRYPT) begin
      state_next = prs80_pkg::perm_fwd(prs80_pkg::sbox_layer_fwd(item_in.state ^ rk_enc));
      state_next = state_next ^ post_enc;
    end else begin
      state_next = prs80_pkg::sbox_layer_inv(prs80_pkg::perm_inv(item_in.state ^ rk_dec));
      state_next = state_next ^ post_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_out.op    <= item_in.op;
      item_out.last  <= item_in.last;
      item_out.state <= state_next;
    end
    if (rst) begin
      item_out.vld <= 1'b0;
    end else if (advance) begin
      item_out.vld <= item_in.vld;
    end
  end

endmodule

`default_nettype wire

### rtl/present80_block_cipher.sv
// PRESENT-80 block cipher, fully unrolled round pipeline.
// Configuration: write key bits 79..16 at index 0 (key_high) and key bits
// 15..0 at index 1 (key_low) on the cfg channel; cfg_ready is always high
// and writes to other indexes are dropped. Write keys only while idle.
// After reset and after each key write, a key expansion unit steps the key
// schedule once per cycle into 32 round-key registers, holding in_stall
// high while it runs.
// Input channel: op (0 encrypt, 1 decrypt), block_in and last_in are taken
// when in_valid is high and in_stall is low. Output channel: block_out and
// last_out are presented with out_valid and taken when out_stall is low.
// There is one register stage per round, the final key add folded into
// the last stage, whose registers drive the outputs. Throughput is one
// block per cycle in either direction, mixed freely, while in_stall is low.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated. Reset empties the pipeline.
`default_nettype none

module present80_block_cipher (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [prs80_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            op,
  input  wire logic [63:0]                     block_in,
  input  wire logic                            last_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [63:0]                          block_out,
  output logic                                 last_out
);

  logic                busy;
  logic [63:0]         rk [prs80_pkg::ROUND_KEYS];
  logic                advance;
  prs80_pkg::item_t    pipe [prs80_pkg::ROUNDS + 1];

  prs80_key_expand u_key_expand (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .rk        (rk)
  );

  assign cfg_ready = 1'b1;

  // hold everything while a finished result waits
  assign advance  = !(pipe[prs80_pkg::ROUNDS].vld && out_stall);
  assign in_stall = busy || !advance;

  always_comb begin
    pipe[0].vld   = in_valid && !busy;
    pipe[0].op    = op;
    pipe[0].last  = last_in;
    pipe[0].state = block_in;
  end

  for (genvar i = 0; i < prs80_pkg::ROUNDS; i++) begin : g_round
    logic [63:0] post_enc;
    logic [63:0] post_dec;

    if (i == prs80_pkg::ROUNDS - 1) begin : g_final
      assign post_enc = rk[prs80_pkg::ROUND_KEYS - 1];
      assign post_dec = rk[0];
    end else begin : g_mid
      assign post_enc = '0;
      assign post_dec = '0;
    end

    prs80_round u_round (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .item_in  (pipe[i]),
      .rk_enc   (rk[i]),
      .rk_dec   (rk[prs80_pkg::ROUND_KEYS - 1 - i]),
      .post_enc (post_enc),
      .post_dec (post_dec),
      .item_out (pipe[i + 1])
    );
  end

  assign out_valid = pipe[prs80_pkg::ROUNDS].vld;
  assign block_out = pipe[prs80_pkg::ROUNDS].state;
  assign last_out  = pipe[prs80_pkg::ROUNDS].last;

endmodule

`default_nettype wire

### verif/present80_block_cipher_tb.sv
`timescale 1ns / 100ps

module present80_block_cipher_tb;

  localparam int RESET_CYCLES     = 7;
  localparam int PIPE_SLACK       = 40;
  localparam int WATCHDOG_CYCLES  = 3000;
  localparam int RCV_HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS      = 10;
  localparam int FIRST_UNUSED_IDX = int'(prs80_pkg::CFG_KEY_LOW) + 1;
  localparam int LAST_IDX         = (1 << prs80_pkg::CFG_IDX_W) - 1;

  localparam logic OP_ENC = 1'(prs80_pkg::OP_ENCRYPT);
  localparam logic OP_DEC = ~OP_ENC;

  // nibble v of the table holds the substitute for v
  localparam logic [63:0] SBOX_ENC = 64'h21748FE3DA09B65C;
  localparam logic [63:0] SBOX_DEC = 64'hA970364BD21C8FE5;

  typedef struct packed {
    logic [63:0] blk;
    logic        last;
  } cipher_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [prs80_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                     cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            op = 1'b0;
  logic [63:0]                     block_in = '0;
  logic                            last_in = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [63:0]                     block_out;
  logic                            last_out;

  logic [63:0]    key_hi_q = '0;
  logic [15:0]    key_lo_q = '0;
  logic [63:0]    round_key [prs80_pkg::ROUND_KEYS];
  cipher_result_t results_due [$];

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int err_count = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  present80_block_cipher DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .block_in  (block_in),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .block_out (block_out),
    .last_out  (last_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] sub_nibbles(input logic [63:0] s, input logic [63:0] box);
    logic [63:0] o;
    for (int n = 0; n < 16; n++) begin
      o[4*n +: 4] = box[4*s[4*n +: 4] +: 4];
    end
    return o;
  endfunction

  // bit k goes to mul*k mod 63, the top bit stays put
  function automatic logic [63:0] spread_bits(input logic [63:0] s, input int mul);
    logic [63:0] o;
    o = '0;
    for (int k = 0; k < 63; k++) begin
      o[(mul * k) % 63] = s[k];
    end
    o[63] = s[63];
    return o;
  endfunction

  function automatic void refresh_round_keys();
    logic [79:0] kr;
    kr = {key_hi_q, key_lo_q};
    for (int r = 0; r < prs80_pkg::ROUND_KEYS; r++) begin
      round_key[r] = kr[79:16];
      kr = {kr[18:0], kr[79:19]};
      kr[79:76] = SBOX_ENC[4*kr[79:76] +: 4];
      kr[19:15] = kr[19:15] ^ 5'(r + 1);
    end
  endfunction

  function automatic logic [63:0] present_crypt(input logic op_v, input logic [63:0] blk);
    logic [63:0] s;
    s = blk;
    if (op_v == OP_ENC) begin
      for (int r = 0; r < prs80_pkg::ROUNDS; r++) begin
        s = spread_bits(sub_nibbles(s ^ round_key[r], SBOX_ENC), 16);
      end
      s = s ^ round_key[prs80_pkg::ROUND_KEYS-1];
    end else begin
      for (int r = prs80_pkg::ROUNDS; r > 0; r--) begin
        s = sub_nibbles(spread_bits(s ^ round_key[r], 4), SBOX_DEC);
      end
      s = s ^ round_key[0];
    end
    return s;
  endfunction

  task automatic flag_error(input string what, input logic [63:0] want, input logic [63:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("ERROR %s: expected %h, got %h", what, want, got);
    end
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= RCV_HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    cipher_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        flag_error("unexpected result block", '0, block_out);
      end else begin
        want = results_due.pop_front();
        if (block_out !== want.blk) flag_error("block_out", want.blk, block_out);
        if (last_out !== want.last) flag_error("last_out", 64'(want.last), 64'(last_out));
      end
    end
  end

  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        stale = 0;
      end else begin
        stale++;
      end
    end
    $display("FAIL present80_block_cipher");
    $finish;
  end

  task automatic send_block(input logic op_v, input logic [63:0] blk, input logic last_v);
    cipher_result_t due;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= op_v;
    block_in <= blk;
    last_in  <= last_v;
    do @(posedge clk); while (in_stall);
    due.blk  = present_crypt(op_v, blk);
    due.last = last_v;
    results_due.push_back(due);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_key_reg(input logic [prs80_pkg::CFG_IDX_W-1:0] idx,
                               input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      prs80_pkg::CFG_KEY_HIGH: key_hi_q = data;
      prs80_pkg::CFG_KEY_LOW:  key_lo_q = data[15:0];
      default: ;
    endcase
    refresh_round_keys();
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [15:0] lo);
    drain_pipeline();
    write_key_reg(prs80_pkg::CFG_KEY_HIGH, hi);
    write_key_reg(prs80_pkg::CFG_KEY_LOW, {$urandom, 16'($urandom), lo});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(input int n);
    logic [63:0] recent_ct [$];
    logic [63:0] blk;
    logic        op_v;
    logic        last_v;
    int          done;
    int          burst;
    done = 0;
    while (done < n) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(9))
          0: blk = 64'd1 << $urandom_range(63);
          1: blk = ~(64'd1 << $urandom_range(63));
          default: blk = {$urandom, $urandom};
        endcase
        op_v = $urandom_range(1) ? OP_DEC : OP_ENC;
        // round trip: decrypt a block encrypted a little earlier
        if (recent_ct.size() != 0 && $urandom_range(3) == 0) begin
          op_v = OP_DEC;
          blk  = recent_ct[$urandom_range(recent_ct.size() - 1)];
        end
        if (op_v == OP_ENC) begin
          recent_ct.push_back(present_crypt(OP_ENC, blk));
          if (recent_ct.size() > 16) void'(recent_ct.pop_front());
        end
        last_v = (i == burst - 1) ^ ($urandom_range(19) == 0);
        send_block(op_v, blk, last_v);
        done++;
      end
    end
  endtask

  task automatic test_reset_key();
    send_block(OP_ENC, 64'h0, 1'b0);
    send_block(OP_ENC, '1, 1'b1);
    send_block(OP_DEC, 64'h0, 1'b1);
    send_block(OP_DEC, '1, 1'b0);
    send_block(OP_ENC, 64'h5555_5555_5555_5555, 1'b1);
    send_block(OP_DEC, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
  endtask

  task automatic test_key_extremes();
    load_key('1, 16'hFFFF);
    send_block(OP_ENC, 64'h0, 1'b1);
    send_block(OP_DEC, '1, 1'b0);
    load_key('1, 16'h0);
    send_block(OP_ENC, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_block(OP_DEC, 64'h8000_0000_0000_0001, 1'b1);
    load_key('0, 16'hFFFF);
    send_block(OP_ENC, '1, 1'b1);
    send_block(OP_DEC, 64'h0, 1'b0);
  endtask

  // only the low 16 bits of a key_low write count
  task automatic test_key_low_stray_bits();
    drain_pipeline();
    write_key_reg(prs80_pkg::CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_0000);
    cfg_valid <= 1'b0;
    send_block(OP_ENC, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_block(OP_DEC, 64'hFEDC_BA98_7654_3210, 1'b1);
  endtask

  task automatic test_unused_index();
    drain_pipeline();
    write_key_reg(prs80_pkg::CFG_IDX_W'(FIRST_UNUSED_IDX), {$urandom, $urandom});
    write_key_reg(prs80_pkg::CFG_IDX_W'(LAST_IDX), '1);
    write_key_reg(prs80_pkg::CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)),
                  {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_block(OP_ENC, {$urandom, $urandom}, 1'b1);
    send_block(OP_DEC, {$urandom, $urandom}, 1'b0);
  endtask

  task automatic test_traffic_phases();
    int snd_pct [4];
    int rcv_pct [4];
    snd_pct = '{0, 85, 0, 14};
    rcv_pct = '{0, 0, 85, 14};
    for (int p = 0; p < 4; p++) begin
      load_key({$urandom, $urandom}, 16'($urandom));
      snd_idle_pct  = snd_pct[p];
      rcv_stall_pct = rcv_pct[p];
      run_traffic(400);
    end
  endtask

  // hold the receiver off while requests keep coming, so the pipe backs up
  task automatic test_fill_under_hold();
    drain_pipeline();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req <= 1'b1;
    run_traffic(80);
  endtask

  task automatic test_sender_pause();
    load_key({$urandom, $urandom}, 16'($urandom));
    snd_idle_pct  = 14;
    rcv_stall_pct = 14;
    for (int i = 0; i < 3; i++) begin
      run_traffic(20);
      drain_pipeline();
    end
  endtask

  initial begin
    refresh_round_keys();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_key_extremes();
    test_key_low_stray_bits();
    test_unused_index();
    test_traffic_phases();
    test_fill_under_hold();
    test_sender_pause();
    drain_pipeline();
    if (err_count == 0 && results_due.size() == 0) begin
      $display("PASS present80_block_cipher");
    end else begin
      $display("FAIL present80_block_cipher");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/prs80_pkg.sv
rtl/prs80_key_expand.sv
rtl/prs80_round.sv
rtl/present80_block_cipher.sv
verif/present80_block_cipher_tb.sv
